FILE: rtl/ipa_pkg.sv
package ipa_pkg;

	// Parse phases.
	localparam logic [2:0] PH_COUNT  = 3'd0;
	localparam logic [2:0] PH_ITEM   = 3'd1;
	localparam logic [2:0] PH_ACOUNT = 3'd2;
	localparam logic [2:0] PH_INDEX  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ASSOC  = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_VERSION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_INDEX  = 1'd1;

	// Result queue.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] item_id;
		logic [7:0]  assoc_count;
		logic [14:0] prop_index;
		logic        essential;
		logic        last_of_run;
	} res_t;

endpackage

FILE: rtl/item_property_association_parser.sv
// A result is queued at its byte's transfer and offered on the m side after those ahead of
// it. Throughput: one byte per cycle while m_tready keeps up and each byte yields at most
// one result; a byte that yields two results (association or header then done) queues
// both at once, and a four-entry queue absorbs these bursts; s_tready drops only while
// fewer than two are free. Reset (arst_n low, asynchronous): parse restarts in the entry
// count phase, the queue empties and both configuration registers return to zero.
module item_property_association_parser import ipa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	// Byte input stream.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tuser,   // [0] box_start
	// Result output stream.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [55:0]          m_tdata,   // [31:0] item_id, [39:32] assoc_count,
	                                        // [54:40] prop_index, [55] essential
	output logic [1:0]           m_tuser,   // [1:0] kind
	output logic                 m_tlast    // last_of_run
);

	// Configuration registers.
	logic [7:0] box_version_q;
	logic       wide_index_q;

	// Parse state.
	logic [2:0]  phase_q;
	logic [1:0]  pos_q;
	logic [31:0] entries_q;
	logic [7:0]  assocs_q;
	logic [31:0] item_q;
	logic [31:0] acc_q;

	// Result queue.
	res_t           queue_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] count_q;

	// Next-state and result signals.
	logic [2:0]  phase_d;
	logic [1:0]  pos_d;
	logic [31:0] entries_d;
	logic [7:0]  assocs_d;
	logic [31:0] item_d;
	logic [31:0] acc_d;
	res_t        res0;
	res_t        res1;
	logic [1:0]  nres;

	logic        in_xfer;
	logic        out_xfer;
	logic [QCW-1:0] count_d;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_xfer  = m_tvalid && m_tready;

	// Room for two results must be left, since one byte can produce two.
	assign s_tready = (count_q <= QCW'(QDEPTH - 2));
	assign m_tvalid = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_version_q <= '0;
			wide_index_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BOX_VERSION) begin
				box_version_q <= cfg_data;
			end else if (cfg_index == REG_WIDE_INDEX) begin
				wide_index_q <= cfg_data[0];
			end
		end
	end

	// One byte of parsing: a start byte first clears the parse; after done the byte is an
	// error, else it is shifted into the field accumulator and, when the field is complete,
	// its value is acted on by phase. Ending an entry may add a second result (box done).
	always_comb begin
		logic [2:0]  ph_e;
		logic [1:0]  pos_e;
		logic [31:0] ent_e;
		logic [7:0]  asc_e;
		logic [31:0] itm_e;
		logic [31:0] acc_e;
		logic [31:0] v;
		logic [2:0]  flen;
		logic        end_entry;

		ph_e  = phase_q;
		pos_e = pos_q;
		ent_e = entries_q;
		asc_e = assocs_q;
		itm_e = item_q;
		acc_e = acc_q;
		if (s_tuser) begin
			ph_e  = PH_COUNT;
			pos_e = '0;
			ent_e = '0;
			asc_e = '0;
			itm_e = '0;
			acc_e = '0;
		end

		phase_d   = ph_e;
		pos_d     = pos_e;
		entries_d = ent_e;
		assocs_d  = asc_e;
		item_d    = itm_e;
		acc_d     = acc_e;
		res0      = '0;
		res1      = '0;
		nres      = 2'd0;
		end_entry = 1'b0;

		v = {acc_e[23:0], s_tdata};

		case (ph_e)
			PH_COUNT:  flen = 3'd4;
			PH_ITEM:   flen = (box_version_q == '0) ? 3'd2 : 3'd4;
			PH_ACOUNT: flen = 3'd1;
			default:   flen = wide_index_q ? 3'd2 : 3'd1;
		endcase

		if (ph_e >= PH_DONE) begin
			// Every byte after done is a trailing byte error.
			phase_d          = PH_DONE;
			res0.kind        = KIND_ERROR;
			res0.last_of_run = 1'b1;
			nres             = 2'd1;
		end else if ({1'b0, pos_e} + 3'd1 < flen) begin
			acc_d = v;
			pos_d = pos_e + 2'd1;
		end else begin
			acc_d = '0;
			pos_d = '0;
			case (ph_e)
				PH_COUNT: begin
					entries_d = v;
					if (v == '0) begin
						phase_d   = PH_DONE;
						res0.kind = KIND_DONE;
						nres      = 2'd1;
					end else begin
						phase_d = PH_ITEM;
					end
				end
				PH_ITEM: begin
					item_d  = (box_version_q == '0) ? {16'd0, v[15:0]} : v;
					phase_d = PH_ACOUNT;
				end
				PH_ACOUNT: begin
					assocs_d         = v[7:0];
					res0.kind        = KIND_HEADER;
					res0.item_id     = itm_e;
					res0.assoc_count = v[7:0];
					nres             = 2'd1;
					if (v[7:0] == '0) begin
						end_entry = 1'b1;
					end else begin
						phase_d = PH_INDEX;
					end
				end
				default: begin
					res0.kind    = KIND_ASSOC;
					res0.item_id = itm_e;
					if (wide_index_q) begin
						res0.prop_index = v[14:0];
						res0.essential  = v[15];
					end else begin
						res0.prop_index = {8'd0, v[6:0]};
						res0.essential  = v[7];
					end
					nres     = 2'd1;
					assocs_d = asc_e - 8'd1;
					if (asc_e == 8'd1) begin
						end_entry = 1'b1;
					end
				end
			endcase

			if (end_entry) begin
				entries_d = ent_e - 32'd1;
				if (ent_e == 32'd1) begin
					phase_d   = PH_DONE;
					res1.kind = KIND_DONE;
					nres      = 2'd2;
				end else begin
					phase_d = PH_ITEM;
				end
			end

			if (nres == 2'd2) begin
				res1.last_of_run = 1'b1;
			end else if (nres == 2'd1) begin
				res0.last_of_run = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			pos_q     <= '0;
			entries_q <= '0;
			assocs_q  <= '0;
			item_q    <= '0;
			acc_q     <= '0;
		end else if (in_xfer) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			entries_q <= entries_d;
			assocs_q  <= assocs_d;
			item_q    <= item_d;
			acc_q     <= acc_d;
		end
	end

	// Queue storage carries payload only, so it needs no reset.
	always_ff @(posedge clk) begin
		if (in_xfer && nres != 2'd0) begin
			queue_q[wr_q] <= res0;
		end
		if (in_xfer && nres == 2'd2) begin
			queue_q[wr_q + QAW'(1)] <= res1;
		end
	end

	assign count_d = count_q + QCW'(in_xfer ? nres : 2'd0) - QCW'(out_xfer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (in_xfer) begin
				wr_q <= wr_q + QAW'(nres);
			end
			if (out_xfer) begin
				rd_q <= rd_q + QAW'(1);
			end
			count_q <= count_d;
		end
	end

	assign m_tdata = {queue_q[rd_q].essential, queue_q[rd_q].prop_index,
	                  queue_q[rd_q].assoc_count, queue_q[rd_q].item_id};
	assign m_tuser = queue_q[rd_q].kind;
	assign m_tlast = queue_q[rd_q].last_of_run;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("result queue overfilled");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_DONE)
		else $error("parse phase out of range");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !s_tuser && phase_q == PH_DONE |=> phase_q == PH_DONE)
		else $error("parse left done without a start byte");

	a_error_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !s_tuser && phase_q == PH_DONE |=> count_q != '0)
		else $error("trailing byte gave no error result");
`endif

endmodule

FILE: verif/ipa_checker.sv
`timescale 1ns / 1ps

module ipa_checker import ipa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tuser,   // [0] box_start
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [55:0]          m_tdata,   // [31:0] item_id, [39:32] assoc_count,
	                                        // [54:40] prop_index, [55] essential
	input  logic [1:0]           m_tuser,   // [1:0] kind
	input  logic                 m_tlast,
	output int                   fail_count,
	output int                   results_owed
);

	// Shadow configuration and parse state.
	logic [7:0]  box_version;
	logic        wide_index;
	logic [2:0]  phase;
	logic [1:0]  byte_pos;
	logic [31:0] entries_left;
	logic [7:0]  assocs_left;
	logic [31:0] item_id;
	logic [31:0] field_acc;

	res_t owed_records[$];
	res_t byte_records[2];
	int   byte_record_n;

	function automatic int field_bytes();
		case (phase)
			PH_COUNT:  return 4;
			PH_ITEM:   return (box_version == 8'd0) ? 2 : 4;
			PH_ACOUNT: return 1;
			default:   return wide_index ? 2 : 1;
		endcase
	endfunction

	task automatic add_record(input logic [1:0] kind, input logic [31:0] id,
			input logic [7:0] count, input logic [14:0] index, input logic ess);
		res_t r;
		r.kind        = kind;
		r.item_id     = id;
		r.assoc_count = count;
		r.prop_index  = index;
		r.essential   = ess;
		r.last_of_run = 1'b0;
		byte_records[byte_record_n] = r;
		byte_record_n++;
	endtask

	task automatic clear_parse();
		phase        = PH_COUNT;
		byte_pos     = 2'd0;
		entries_left = 32'd0;
		assocs_left  = 8'd0;
		item_id      = 32'd0;
		field_acc    = 32'd0;
	endtask

	// An entry has ended: either more entries follow or the box is done.
	task automatic close_entry();
		entries_left = entries_left - 32'd1;
		if (entries_left == 32'd0) begin
			phase = PH_DONE;
			add_record(KIND_DONE, 32'd0, 8'd0, 15'd0, 1'b0);
		end else begin
			phase = PH_ITEM;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic start);
		logic [31:0] v;
		byte_record_n = 0;
		if (start)
			clear_parse();
		if (phase >= PH_DONE) begin
			phase = PH_DONE;
			add_record(KIND_ERROR, 32'd0, 8'd0, 15'd0, 1'b0);
		end else begin
			field_acc = {field_acc[23:0], b};
			// A field shortened by a register change completes with what it has.
			if (int'(byte_pos) + 1 < field_bytes()) begin
				byte_pos = byte_pos + 2'd1;
			end else begin
				v         = field_acc;
				field_acc = 32'd0;
				byte_pos  = 2'd0;
				case (phase)
					PH_COUNT: begin
						entries_left = v;
						if (v == 32'd0) begin
							phase = PH_DONE;
							add_record(KIND_DONE, 32'd0, 8'd0, 15'd0, 1'b0);
						end else begin
							phase = PH_ITEM;
						end
					end
					PH_ITEM: begin
						item_id = (box_version == 8'd0) ? {16'd0, v[15:0]} : v;
						phase   = PH_ACOUNT;
					end
					PH_ACOUNT: begin
						assocs_left = v[7:0];
						add_record(KIND_HEADER, item_id, assocs_left, 15'd0, 1'b0);
						if (assocs_left == 8'd0)
							close_entry();
						else
							phase = PH_INDEX;
					end
					default: begin
						if (wide_index)
							add_record(KIND_ASSOC, item_id, 8'd0, v[14:0], v[15]);
						else
							add_record(KIND_ASSOC, item_id, 8'd0, {8'd0, v[6:0]}, v[7]);
						assocs_left = assocs_left - 8'd1;
						if (assocs_left == 8'd0)
							close_entry();
					end
				endcase
			end
		end
		if (byte_record_n > 0)
			byte_records[byte_record_n - 1].last_of_run = 1'b1;
		for (int i = 0; i < byte_record_n; i++)
			owed_records.push_back(byte_records[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		res_t want;
		if (!arst_n) begin
			box_version = 8'd0;
			wide_index  = 1'b0;
			clear_parse();
			owed_records.delete();
			fail_count   = 0;
			results_owed = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_records.size() == 0) begin
					$error("unexpected result: kind %0d, item_id %0h", m_tuser, m_tdata[31:0]);
					fail_count++;
				end else begin
					want = owed_records.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("item_id", want.item_id, m_tdata[31:0]);
					check_field("assoc_count", 32'(want.assoc_count), 32'(m_tdata[39:32]));
					check_field("prop_index", 32'(want.prop_index), 32'(m_tdata[54:40]));
					check_field("essential", 32'(want.essential), 32'(m_tdata[55]));
					check_field("last_of_run", 32'(want.last_of_run), 32'(m_tlast));
				end
			end
			// A byte taken at the same edge as a register write still sees the old value.
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tuser);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BOX_VERSION)
					box_version = cfg_data;
				else if (cfg_index == REG_WIDE_INDEX)
					wide_index = cfg_data[0];
			end
			results_owed = owed_records.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Top of the testbench for the item property association parser. It only
// builds byte streams, drives the three channels and gives the verdict; the
// checker instance beside the block predicts every result and compares it.
module testbench;
	import ipa_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	// Roughly how many random bytes each configuration phase carries.
	localparam int PHASE_BYTES  = 48;
	// Longest wait either side draws before an item.
	localparam int MAX_WAIT     = 6;

	// One byte of the input stream together with its restart flag.
	typedef struct packed {
		logic       start;
		logic [7:0] data;
	} box_byte_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [55:0]          m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;
	int                   fail_count;
	int                   results_owed;

	// Bytes built but not yet sent, and the generator's view of the registers,
	// which decides how wide the item ID and index fields are laid out.
	box_byte_t  byte_q[$];
	logic [7:0] cur_version;
	logic       cur_wide;
	// When set, neither side idles, so the block runs at full rate.
	bit         steady_flow;
	int         cycle_count = 0;
	int         sent_in_phase;

	item_property_association_parser DUT (.*);

	ipa_checker checker_inst (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Appends a big-endian field; only its first byte may carry the restart flag.
	task automatic push_field(input logic [31:0] value, input int nbytes, input logic start);
		box_byte_t b;
		for (int i = nbytes - 1; i >= 0; i--) begin
			b.start = (i == nbytes - 1) ? start : 1'b0;
			b.data  = value[8*i +: 8];
			byte_q.push_back(b);
		end
	endtask

	// A well-formed box laid out for the current register values, followed by
	// a few trailing bytes that should each come back as an error.
	task automatic push_box(input int entries, input int trailing);
		int n_assoc;
		push_field(entries, 4, 1'b1);
		repeat (entries) begin
			push_field($urandom, (cur_version == 8'd0) ? 2 : 4, 1'b0);
			n_assoc = $urandom_range(0, 4);
			push_field(n_assoc, 1, 1'b0);
			repeat (n_assoc)
				push_field($urandom, cur_wide ? 2 : 1, 1'b0);
		end
		repeat (trailing)
			push_field($urandom, 1, 1'b0);
	endtask

	// A box whose counts are far too large for what follows; the next restart
	// abandons it. This is where the extreme entry and association counts live.
	task automatic push_abandoned();
		push_field($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom, 4, 1'b1);
		push_field($urandom, (cur_version == 8'd0) ? 2 : 4, 1'b0);
		push_field($urandom_range(0, 1) ? 32'hFF : $urandom_range(5, 255), 1, 1'b0);
		repeat ($urandom_range(0, 3))
			push_field($urandom, cur_wide ? 2 : 1, 1'b0);
	endtask

	// Sends one byte after a random gap, then holds it until the transfer.
	task automatic send_byte(input box_byte_t b);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b.data;
		s_tuser  <= b.start;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic flush_queue();
		while (byte_q.size() > 0) begin
			send_byte(byte_q.pop_front());
			sent_in_phase++;
		end
	endtask

	// Stops sending until every predicted result has come out. Bytes in the
	// middle of a field produce nothing, so the block is then left to settle
	// before anything else happens.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	// Register writes only happen with the block quiet. The parse itself may
	// still be halfway through a field, which is how a length change inside a
	// field gets exercised.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_BOX_VERSION)
			cur_version = data;
		else
			cur_wide = data[0];
	endtask

	// Result side: draws a stall before each result, then accepts it.
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		int         sel;
		logic [7:0] ver;
		logic [7:0] wide_data;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_BOX_VERSION;
		cfg_data      = 8'd0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'd0;
		s_tuser       = 1'b0;
		cur_version   = 8'd0;
		cur_wide      = 1'b0;
		steady_flow   = 1'b0;
		sent_in_phase = 0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part, with the reset register values first.
		// The parse starts without any restart flag: a zero entry count gives
		// done at once, and the bytes after it are trailing errors.
		push_field(32'd0, 4, 1'b0);
		push_field(32'hFF, 1, 1'b0);
		push_field(32'h00, 1, 1'b0);
		// One entry with the largest short item ID and no associations: the
		// count byte gives the header and then done.
		push_field(32'd1, 4, 1'b1);
		push_field(32'hFFFF, 2, 1'b0);
		push_field(32'd0, 1, 1'b0);
		// Narrow indexes at both extremes; the last association of the last
		// entry gives the association and then done from one byte.
		push_field(32'd1, 4, 1'b1);
		push_field(32'h1234, 2, 1'b0);
		push_field(32'd2, 1, 1'b0);
		push_field(32'hFF, 1, 1'b0);
		push_field(32'h00, 1, 1'b0);
		flush_queue();

		// Long item IDs and wide indexes, again at both extremes.
		write_reg(REG_BOX_VERSION, 8'hFF);
		write_reg(REG_WIDE_INDEX, 8'h01);
		push_field(32'd1, 4, 1'b1);
		push_field(32'hFFFF_FFFF, 4, 1'b0);
		push_field(32'd2, 1, 1'b0);
		push_field(32'hFFFF, 2, 1'b0);
		push_field(32'h0000, 2, 1'b0);
		flush_queue();

		// Random part: each phase picks new register values, continues
		// whatever parse the previous phase left open, then sends mostly
		// well-formed boxes with some abandoned boxes and loose noise.
		for (int phase_i = 0; phase_i < 8; phase_i++) begin
			steady_flow = (phase_i % 3 == 2);
			case (phase_i)
				0:       ver = 8'd0;
				1:       ver = 8'd255;
				2:       ver = 8'd1;
				default: ver = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
			endcase
			wide_data = 8'($urandom_range(0, 255));
			if (phase_i < 2)
				wide_data[0] = phase_i[0];
			write_reg(REG_BOX_VERSION, ver);
			write_reg(REG_WIDE_INDEX, wide_data);

			// Bytes that carry on the parse cut off at the end of the last phase.
			repeat ($urandom_range(1, 3))
				push_field($urandom, 1, 1'b0);
			flush_queue();

			sent_in_phase = 0;
			while (sent_in_phase < PHASE_BYTES) begin
				sel = $urandom_range(0, 9);
				if (sel < 7)
					push_box(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4),
						$urandom_range(0, 2));
				else if (sel < 9)
					push_abandoned();
				else
					repeat ($urandom_range(1, 4))
						push_field($urandom, 1, $urandom_range(0, 3) == 0);
				flush_queue();
			end

			// End the phase partway through a box, so that the register change
			// that follows lands inside a field.
			push_box($urandom_range(1, 3), 0);
			repeat ($urandom_range(1, 5))
				void'(byte_q.pop_back());
			flush_queue();
		end

		// Drain: everything predicted must arrive, then a short quiet spell
		// gives a stray result the chance to show up.
		wait_idle();
		repeat (10)
			@(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
